// ===== rtl/bbc_pkg.sv =====
// Bracket balance checker package: bracket kinds, character codes and the
// decoded-operation and result structs shared by the decoder, stack and top.
// No dependencies.
package bbc_pkg;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	localparam int NUM_KINDS = 3;

	localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28; // (
	localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29; // )
	localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B; // [
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D; // ]
	localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B; // {
	localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D; // }

	typedef struct packed {
		logic  is_open;
		logic  is_close;
		kind_t kind;
	} op_t;

	typedef struct packed {
		logic paren_bad;
		logic square_bad;
		logic curly_bad;
		logic stack_overflow;
	} res_t;

endpackage

// ===== rtl/bbc_decode.sv =====
// Character decoder: maps one byte to an open/close bracket operation.
// Depends on bbc_pkg.
module bbc_decode
	import bbc_pkg::*;
(
	input  logic [7:0] char_code,
	output op_t        op
);

	always_comb begin
		op = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
		unique case (char_code)
			CHAR_OPEN_ROUND: begin
				op.is_open = 1'b1;
				op.kind    = KIND_ROUND;
			end
			CHAR_OPEN_SQUARE: begin
				op.is_open = 1'b1;
				op.kind    = KIND_SQUARE;
			end
			CHAR_OPEN_CURLY: begin
				op.is_open = 1'b1;
				op.kind    = KIND_CURLY;
			end
			CHAR_CLOSE_ROUND: begin
				op.is_close = 1'b1;
				op.kind     = KIND_ROUND;
			end
			CHAR_CLOSE_SQUARE: begin
				op.is_close = 1'b1;
				op.kind     = KIND_SQUARE;
			end
			CHAR_CLOSE_CURLY: begin
				op.is_close = 1'b1;
				op.kind     = KIND_CURLY;
			end
			default: begin
				op.is_open = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/bbc_stack.sv =====
// Bracket stack: memory of kinds with a registered top entry, fill level,
// per-kind open counters, error and overflow flags. Depends on bbc_pkg.
module bbc_stack
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  op_t  op,
	input  logic last,
	output res_t res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	kind_t            mem [STACK_DEPTH];
	kind_t            top_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    cnt_q [NUM_KINDS];
	logic [CW-1:0]    cnt_d [NUM_KINDS];
	logic [2:0]       err_q;
	logic [2:0]       err_d;
	logic             ovf_q;
	logic             ovf_d;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic             mismatch;
	logic [AW-1:0]    wr_idx;
	logic [AW-1:0]    rd_idx;
	logic [CW-1:0]    fill_m2;

	assign full     = (fill_q == CW'(STACK_DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = op.is_open && !full;
	assign do_pop   = op.is_close && !empty && (top_q == op.kind);
	assign mismatch = op.is_close && !do_pop;
	assign err_d    = err_q | (mismatch ? (3'b001 << op.kind) : 3'b000);
	assign ovf_d    = ovf_q | (op.is_open && full);
	assign wr_idx   = fill_q[AW-1:0];
	// entry below the top becomes the new top on a pop
	assign fill_m2  = fill_q - CW'(2);
	assign rd_idx   = fill_m2[AW-1:0];

	always_comb begin
		for (int k = 0; k < NUM_KINDS; k++) begin
			cnt_d[k] = cnt_q[k]
				+ CW'(do_push && (op.kind == kind_t'(k)))
				- CW'(do_pop && (op.kind == kind_t'(k)));
		end
	end

	assign res.paren_bad      = err_d[KIND_ROUND]  || (cnt_d[KIND_ROUND]  != '0);
	assign res.square_bad     = err_d[KIND_SQUARE] || (cnt_d[KIND_SQUARE] != '0);
	assign res.curly_bad      = err_d[KIND_CURLY]  || (cnt_d[KIND_CURLY]  != '0);
	assign res.stack_overflow = ovf_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			err_q  <= '0;
			ovf_q  <= 1'b0;
			for (int k = 0; k < NUM_KINDS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (step) begin
			if (last) begin
				fill_q <= '0;
				err_q  <= '0;
				ovf_q  <= 1'b0;
				for (int k = 0; k < NUM_KINDS; k++) begin
					cnt_q[k] <= '0;
				end
			end else begin
				err_q <= err_d;
				ovf_q <= ovf_d;
				for (int k = 0; k < NUM_KINDS; k++) begin
					cnt_q[k] <= cnt_d[k];
				end
				if (do_push) begin
					fill_q <= fill_q + CW'(1);
				end else if (do_pop) begin
					fill_q <= fill_q - CW'(1);
				end
			end
		end
	end

	// stack storage and top entry; top is valid whenever fill_q is nonzero
	always_ff @(posedge clk) begin
		if (step && do_push) begin
			mem[wr_idx] <= op.kind;
			top_q       <= op.kind;
		end else if (step && do_pop) begin
			top_q <= mem[rd_idx];
		end
	end

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// Bracket balance checker top level: input register, decoder, bracket stack
// and result register. Depends on bbc_pkg, bbc_decode and bbc_stack.
// Result path: the last transaction of a string is registered in stage 1, steps
// the stack and loads the result register, which raises out_valid.
// Throughput: one transaction per cycle while no last transaction waits on out_stall.
// Reset: arst_n clears all control state, fill level, counters and flags;
// stack memory contents are not cleared and are never used before written.
module bracket_balance_checker
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       paren_bad,
	output logic       square_bad,
	output logic       curly_bad,
	output logic       stack_overflow
);

	op_t  op_in;
	op_t  op_s1;
	logic last_s1;
	logic valid_s1;
	logic advance;
	res_t res;
	res_t res_q;
	logic out_valid_q;

	// Decode in front of the input register so stage 1 holds a compact op.
	bbc_decode u_decode (
		.char_code (char_code),
		.op        (op_in)
	);

	// Stage 1 moves into the stack unless it is a last transaction whose
	// result has nowhere to go (result register full and stalled).
	// Non-last transactions never wait on the output side.
	assign advance  = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op_in;
			last_s1 <= is_last;
		end
	end

	bbc_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.last   (last_s1),
		.res    (res)
	);

	// Result register: loaded on a last transaction, held while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign paren_bad      = res_q.paren_bad;
	assign square_bad     = res_q.square_bad;
	assign curly_bad      = res_q.curly_bad;
	assign stack_overflow = res_q.stack_overflow;

endmodule

// ===== tb/bbc_checker.sv =====
// Scoreboard for the bracket balance checker: watches both channels, keeps its own
// bracket stack, open counters and flags, and compares every result transaction.
// Depends on bbc_pkg.
module bbc_checker
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       paren_bad,
	input  logic       square_bad,
	input  logic       curly_bad,
	input  logic       stack_overflow,
	output int         mismatches,
	output int         verdicts_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	kind_t                held_kinds [STACK_DEPTH];
	int                   fill;
	int                   open_cnt [NUM_KINDS];
	logic [NUM_KINDS-1:0] err_bits;
	logic                 dropped_open;
	res_t                 verdicts_due [$];
	res_t                 want;
	res_t                 got;
	int                   fail_q = 0;
	int                   pending_q = 0;

	assign mismatches       = fail_q;
	assign verdicts_pending = pending_q;

	task automatic wipe_string();
		fill = 0;
		foreach (open_cnt[i])
			open_cnt[i] = 0;
		err_bits     = '0;
		dropped_open = 1'b0;
	endtask

	// One character: push, pop or flag, and a verdict when the string ends.
	task automatic absorb_char(input logic [7:0] c, input logic last);
		kind_t k;
		logic  opener;
		logic  closer;
		res_t  v;
		k      = KIND_ROUND;
		opener = 1'b0;
		closer = 1'b0;
		case (c)
			CHAR_OPEN_ROUND: begin
				opener = 1'b1;
				k = KIND_ROUND;
			end
			CHAR_OPEN_SQUARE: begin
				opener = 1'b1;
				k = KIND_SQUARE;
			end
			CHAR_OPEN_CURLY: begin
				opener = 1'b1;
				k = KIND_CURLY;
			end
			CHAR_CLOSE_ROUND: begin
				closer = 1'b1;
				k = KIND_ROUND;
			end
			CHAR_CLOSE_SQUARE: begin
				closer = 1'b1;
				k = KIND_SQUARE;
			end
			CHAR_CLOSE_CURLY: begin
				closer = 1'b1;
				k = KIND_CURLY;
			end
			default: ;
		endcase
		if (opener) begin
			if (fill >= STACK_DEPTH) begin
				dropped_open = 1'b1;
			end else begin
				held_kinds[fill] = k;
				fill++;
				open_cnt[k]++;
			end
		end
		if (closer) begin
			if (fill > 0 && held_kinds[fill-1] == k) begin
				fill--;
				open_cnt[k]--;
			end else begin
				err_bits[k] = 1'b1;
			end
		end
		if (last) begin
			v.paren_bad      = err_bits[KIND_ROUND] || open_cnt[KIND_ROUND] > 0;
			v.square_bad     = err_bits[KIND_SQUARE] || open_cnt[KIND_SQUARE] > 0;
			v.curly_bad      = err_bits[KIND_CURLY] || open_cnt[KIND_CURLY] > 0;
			v.stack_overflow = dropped_open;
			verdicts_due.push_back(v);
			wipe_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_string();
			verdicts_due.delete();
		end else begin
			if (in_valid && !in_stall)
				absorb_char(char_code, is_last);
			if (out_valid && !out_stall) begin
				got.paren_bad      = paren_bad;
				got.square_bad     = square_bad;
				got.curly_bad      = curly_bad;
				got.stack_overflow = stack_overflow;
				if (verdicts_due.size() == 0) begin
					if (fail_q < 10)
						$display("%0t: result with none pending: pscO=%b%b%b%b",
							$realtime, got.paren_bad, got.square_bad, got.curly_bad,
							got.stack_overflow);
					fail_q++;
				end else begin
					want = verdicts_due.pop_front();
					if (got !== want) begin
						if (fail_q < 10)
							$display("%0t: pscO expected %b%b%b%b, got %b%b%b%b",
								$realtime, want.paren_bad, want.square_bad, want.curly_bad,
								want.stack_overflow, got.paren_bad, got.square_bad,
								got.curly_bad, got.stack_overflow);
						fail_q++;
					end
				end
			end
		end
		pending_q = verdicts_due.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the bracket balance checker testbench: clock, reset, string stimulus and verdict.
// Depends on bbc_pkg, bracket_balance_checker and bbc_checker.
module testbench;
	import bbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = 64;
	localparam int ITEM_GOAL = 1800;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = '0;
	logic       is_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       paren_bad;
	logic       square_bad;
	logic       curly_bad;
	logic       stack_overflow;

	int         mismatches;
	int         verdicts_pending;

	// Random idling on both channels is enabled only when this is set.
	logic       idle_ok = 1'b0;

	// Characters of the string being sent; the final one carries is_last.
	logic [7:0] line_buf [$];
	int         chars_sent = 0;
	int         lines_done = 0;

	// 8 ns clock; falling edge at time 0, so drives land mid-cycle.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	bracket_balance_checker #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.paren_bad     (paren_bad),
		.square_bad    (square_bad),
		.curly_bad     (curly_bad),
		.stack_overflow(stack_overflow)
	);

	bbc_checker #(
		.STACK_DEPTH(DEPTH)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.is_last         (is_last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.paren_bad       (paren_bad),
		.square_bad      (square_bad),
		.curly_bad       (curly_bad),
		.stack_overflow  (stack_overflow),
		.mismatches      (mismatches),
		.verdicts_pending(verdicts_pending)
	);

	// Result side back-pressure: out_stall is raised with a chance of 18 in 100 while idling is on.
	always @(negedge clk) begin
		out_stall <= idle_ok && ($urandom_range(99) < 18);
	end

	function automatic logic [7:0] opener_of(kind_t k);
		case (k)
			KIND_ROUND:  return CHAR_OPEN_ROUND;
			KIND_SQUARE: return CHAR_OPEN_SQUARE;
			default:     return CHAR_OPEN_CURLY;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(kind_t k);
		case (k)
			KIND_ROUND:  return CHAR_CLOSE_ROUND;
			KIND_SQUARE: return CHAR_CLOSE_SQUARE;
			default:     return CHAR_CLOSE_CURLY;
		endcase
	endfunction

	function automatic logic [7:0] any_bracket();
		kind_t k;
		k = kind_t'($urandom_range(2));
		return $urandom_range(1) ? opener_of(k) : closer_of(k);
	endfunction

	// Any byte that the block ignores, so balanced strings stay balanced.
	function automatic logic [7:0] filler();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c inside {CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND, CHAR_OPEN_SQUARE,
			CHAR_CLOSE_SQUARE, CHAR_OPEN_CURLY, CHAR_CLOSE_CURLY});
		return c;
	endfunction

	// One input transaction. Valid may drop for random idle cycles first; once
	// raised it holds with a steady payload until a rising edge sees no stall.
	// Returns at the following falling edge.
	task automatic put_char(input logic [7:0] c, input logic last);
		while (idle_ok && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		is_last   <= last;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			put_char(line_buf[i], i == line_buf.size() - 1);
		chars_sent += line_buf.size();
	endtask

	task automatic send_text(input string s);
		line_buf.delete();
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
		send_line();
	endtask

	// Drop valid and hold off until the checker has seen every pending result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (verdicts_pending != 0)
			@(negedge clk);
	endtask

	// Random string. Most are well-formed nesting with random filler, a share
	// of those with one character replaced by a bracket, deleted, or a bracket inserted;
	// the rest are bracket-heavy noise or deep nesting around the stack depth, which
	// exercises full stack, dropped openers and the sticky overflow flag.
	task automatic build_line();
		int         mode;
		int         pos;
		kind_t      k;
		kind_t      kinds [$];
		mode = $urandom_range(99);
		line_buf.delete();
		if (mode < 75) begin
			repeat ($urandom_range(1, 24)) begin
				case ($urandom_range(2))
					0: begin
						k = kind_t'($urandom_range(2));
						kinds.push_back(k);
						line_buf.push_back(opener_of(k));
					end
					1: begin
						if (kinds.size() > 0)
							line_buf.push_back(closer_of(kinds.pop_back()));
						else
							line_buf.push_back(filler());
					end
					default: line_buf.push_back(filler());
				endcase
			end
			while (kinds.size() > 0)
				line_buf.push_back(closer_of(kinds.pop_back()));
			if (mode >= 55) begin
				pos = $urandom_range(line_buf.size() - 1);
				case ($urandom_range(2))
					0: line_buf[pos] = any_bracket();
					1: begin
						if (line_buf.size() > 1)
							line_buf.delete(pos);
						else
							line_buf[pos] = any_bracket();
					end
					default: line_buf.insert(pos, any_bracket());
				endcase
			end
		end else if (mode < 90) begin
			repeat ($urandom_range(1, 20))
				line_buf.push_back($urandom_range(99) < 70 ? any_bracket() : 8'($urandom));
		end else begin
			repeat ($urandom_range(DEPTH - 4, DEPTH + 8)) begin
				k = kind_t'($urandom_range(2));
				kinds.push_back(k);
				line_buf.push_back(opener_of(k));
			end
			// openers past the depth are dropped by the block; close only stored ones
			while (kinds.size() > DEPTH)
				void'(kinds.pop_back());
			repeat ($urandom_range(kinds.size()))
				line_buf.push_back(closer_of(kinds.pop_back()));
			if ($urandom_range(1))
				line_buf.push_back(filler());
		end
	endtask

	initial begin
		// reset held from the start, then released mid-cycle
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed strings, no idling: each bracket kind balanced, closers on an
		// empty stack, a mismatched closer, crossed nesting, openers left at
		// the end, the byte extremes alone, and brackets among ignored bytes.
		send_text("()");
		send_text("[]");
		send_text("{}");
		send_text(")");
		send_text("]}");
		send_text("(]");
		send_text("([)]");
		send_text("{[(");
		line_buf = '{8'hFF};
		send_line();
		line_buf = '{8'h00};
		send_line();
		send_text("a(b)c");

		// Random strings; a stretch of them runs with no idling at all, and every
		// so often the sender holds off until all results are back.
		while (chars_sent < ITEM_GOAL) begin
			idle_ok = (lines_done < 40) || (lines_done > 70);
			build_line();
			send_line();
			lines_done++;
			if (lines_done % 25 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && verdicts_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule
